// ===== rtl/rational_arithmetic_unit_macros.svh =====
// assertion macros used by the rational arithmetic unit checker
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rational unit check failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rational unit check failed");

`endif

// ===== rtl/rau_pkg.sv =====
// shared constants and controller/datapath interface types of the rational unit
package rau_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int PORT_BITS      = 32;
   localparam int OP_BITS        = 3;
   localparam int STATUS_BITS    = 2;

   localparam logic [OP_BITS-1:0] OP_ADD = 3'd0;
   localparam logic [OP_BITS-1:0] OP_SUB = 3'd1;
   localparam logic [OP_BITS-1:0] OP_MUL = 3'd2;
   localparam logic [OP_BITS-1:0] OP_DIV = 3'd3;
   localparam logic [OP_BITS-1:0] OP_RED = 3'd4;
   localparam logic [OP_BITS-1:0] OP_EQU = 3'd5;

   localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVF  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_DIV0 = 2'd2;

   localparam logic [1:0] MUL_IDX_0 = 2'd0;
   localparam logic [1:0] MUL_IDX_1 = 2'd1;
   localparam logic [1:0] MUL_IDX_2 = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_idx;
      logic       comb;
      logic       gcd_init;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
      logic       save_n;
      logic       red_end;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               err;
      logic               gcd_done;
      logic               div_last;
      logic               pass;
   } sts_type;

endpackage

// ===== rtl/rau_datapath.sv =====
// operand registers, multiplier, binary gcd, restoring divider and result registers
module rau_datapath #(
   parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
   input  logic                               clock,
   input  rau_pkg::cmd_type                   cmd,
   output rau_pkg::sts_type                   sts,
   input  logic [rau_pkg::OP_BITS-1:0]        req_opcode,
   input  logic                               req_a_sign,
   input  logic [rau_pkg::PORT_BITS-1:0]      req_a_numerator,
   input  logic [rau_pkg::PORT_BITS-1:0]      req_a_denominator,
   input  logic                               req_b_sign,
   input  logic [rau_pkg::PORT_BITS-1:0]      req_b_numerator,
   input  logic [rau_pkg::PORT_BITS-1:0]      req_b_denominator,
   output logic                               rsp_res_sign,
   output logic [rau_pkg::PORT_BITS-1:0]      rsp_res_numerator,
   output logic [rau_pkg::PORT_BITS-1:0]      rsp_res_denominator,
   output logic [rau_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic                               rsp_is_equal
);

   localparam int W  = VALUE_BITS;
   localparam int KW = $clog2(W);
   localparam int PB = rau_pkg::PORT_BITS;

   // operand capture
   logic [W-1:0] an, ad, bn, bd, ad_n, bd_n;
   logic         anz, bnz, op_sub, op_div, ld_err;

   logic [rau_pkg::OP_BITS-1:0] op_ff;
   logic         xs_ff, ys_ff, err_ff, pass_ff;
   logic [W-1:0] xn_ff, xd_ff, yn_ff, yd_ff;

   assign an     = req_a_numerator[W-1:0];
   assign ad     = req_a_denominator[W-1:0];
   assign bn     = req_b_numerator[W-1:0];
   assign bd     = req_b_denominator[W-1:0];
   assign anz    = |an;
   assign bnz    = |bn;
   assign ad_n   = anz ? ad : W'(1);
   assign bd_n   = bnz ? bd : W'(1);
   assign op_sub = (req_opcode == rau_pkg::OP_SUB);
   assign op_div = (req_opcode == rau_pkg::OP_DIV);
   assign ld_err = (req_opcode <= rau_pkg::OP_EQU) &&
                   ((ad_n == '0) || ((req_opcode != rau_pkg::OP_RED) && (bd_n == '0)) ||
                    (op_div && !bnz));

   // multiplier
   logic [W-1:0]   ma, mb;
   logic [2*W-1:0] prod;
   logic [2*W-1:0] p0_ff, p1_ff, p2_ff;
   logic           mulop;

   assign mulop = (op_ff == rau_pkg::OP_MUL) || (op_ff == rau_pkg::OP_DIV);

   always_comb begin
      case (cmd.mul_idx)
         rau_pkg::MUL_IDX_0: begin
            ma = xn_ff;
            mb = mulop ? yn_ff : yd_ff;
         end
         rau_pkg::MUL_IDX_1: begin
            ma = yn_ff;
            mb = xd_ff;
         end
         default: begin
            ma = xd_ff;
            mb = yd_ff;
         end
      endcase
   end

   assign prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};

   // combine products into the add or multiply result
   logic         cmb_s, cmb_ovf, eqd, same, ge;
   logic [W-1:0] cmb_n, cmb_d, u, v, den;
   logic [W:0]   sum, dif;

   always_comb begin
      eqd  = (xd_ff == yd_ff);
      same = (xs_ff == ys_ff);
      u    = eqd ? xn_ff : p0_ff[W-1:0];
      v    = eqd ? yn_ff : p1_ff[W-1:0];
      den  = eqd ? xd_ff : p2_ff[W-1:0];
      sum  = {1'b0, u} + {1'b0, v};
      ge   = (u >= v);
      dif  = ge ? ({1'b0, u} - {1'b0, v}) : ({1'b0, v} - {1'b0, u});
      if (mulop) begin
         cmb_ovf = (|p0_ff[2*W-1:W]) || (|p2_ff[2*W-1:W]);
         cmb_s   = xs_ff ^ ys_ff;
         cmb_n   = p0_ff[W-1:0];
         cmb_d   = p2_ff[W-1:0];
      end else begin
         cmb_ovf = (!eqd && ((|p0_ff[2*W-1:W]) || (|p1_ff[2*W-1:W]) ||
                             (|p2_ff[2*W-1:W]))) || (same && sum[W]);
         cmb_s   = same ? xs_ff : (ge ? xs_ff : ys_ff);
         cmb_n   = same ? sum[W-1:0] : dif[W-1:0];
         cmb_d   = den;
      end
   end

   // binary gcd
   logic [W-1:0]  gx_ff, gy_ff, gx_in, gy_in, g_val;
   logic [KW-1:0] gk_ff, gk_in;

   always_comb begin
      gx_in = gx_ff;
      gy_in = gy_ff;
      gk_in = gk_ff;
      if (!gx_ff[0] && !gy_ff[0]) begin
         gx_in = gx_ff >> 1;
         gy_in = gy_ff >> 1;
         gk_in = gk_ff + KW'(1);
      end else if (!gx_ff[0]) begin
         gx_in = gx_ff >> 1;
      end else if (!gy_ff[0]) begin
         gy_in = gy_ff >> 1;
      end else if (gx_ff >= gy_ff) begin
         gx_in = gx_ff - gy_ff;
      end else begin
         gy_in = gy_ff - gx_ff;
      end
   end

   assign g_val = (gx_ff | gy_ff) << gk_ff;

   // restoring divider, one quotient bit per cycle
   logic [W-1:0]  dv_q_ff, dv_r_ff, g_ff, dv_r_in, rn_ff, ea_n_ff, ea_d_ff;
   logic [KW-1:0] dv_cnt_ff;
   logic [W:0]    rr, rsub;
   logic          dge;

   assign rr      = {dv_r_ff, dv_q_ff[W-1]};
   assign rsub    = rr - {1'b0, g_ff};
   assign dge     = (rr >= {1'b0, g_ff});
   assign dv_r_in = dge ? rsub[W-1:0] : rr[W-1:0];

   // result and output registers
   logic                            rs_ff, req_ff, o_s_ff, o_eq_ff;
   logic [W-1:0]                    rn_res_ff, rd_res_ff, o_n_ff, o_d_ff;
   logic [rau_pkg::STATUS_BITS-1:0] st_ff, o_st_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         xs_ff     <= anz & req_a_sign;
         xn_ff     <= an;
         xd_ff     <= ad_n;
         ys_ff     <= bnz & (req_b_sign ^ op_sub);
         yn_ff     <= op_div ? bd_n : bn;
         yd_ff     <= op_div ? bn : bd_n;
         err_ff    <= ld_err;
         pass_ff   <= 1'b0;
         rs_ff     <= 1'b0;
         rn_res_ff <= '0;
         rd_res_ff <= W'(1);
         st_ff     <= ld_err ? rau_pkg::ST_DIV0 : rau_pkg::ST_OK;
         req_ff    <= 1'b0;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_idx)
            rau_pkg::MUL_IDX_0: p0_ff <= prod;
            rau_pkg::MUL_IDX_1: p1_ff <= prod;
            default:            p2_ff <= prod;
         endcase
      end
      if (cmd.comb) begin
         if (cmb_ovf) begin
            st_ff <= rau_pkg::ST_OVF;
         end else if (cmb_n != '0) begin
            rs_ff     <= cmb_s;
            rn_res_ff <= cmb_n;
            rd_res_ff <= cmb_d;
         end
      end
      if (cmd.gcd_init) begin
         gx_ff <= pass_ff ? yn_ff : xn_ff;
         gy_ff <= pass_ff ? yd_ff : xd_ff;
         gk_ff <= '0;
      end else if (cmd.gcd_step) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         gk_ff <= gk_in;
      end
      if (cmd.div_init) begin
         dv_q_ff   <= cmd.save_n ? (pass_ff ? yd_ff : xd_ff) : (pass_ff ? yn_ff : xn_ff);
         dv_r_ff   <= '0;
         dv_cnt_ff <= '0;
         g_ff      <= g_val;
      end else if (cmd.div_step) begin
         dv_q_ff   <= {dv_q_ff[W-2:0], dge};
         dv_r_ff   <= dv_r_in;
         dv_cnt_ff <= dv_cnt_ff + KW'(1);
      end
      if (cmd.save_n) begin
         rn_ff <= dv_q_ff;
      end
      if (cmd.red_end) begin
         if (op_ff == rau_pkg::OP_EQU) begin
            if (!pass_ff) begin
               ea_n_ff <= rn_ff;
               ea_d_ff <= dv_q_ff;
               pass_ff <= 1'b1;
            end else begin
               req_ff <= (xs_ff == ys_ff) && (ea_n_ff == rn_ff) && (ea_d_ff == dv_q_ff);
            end
         end else begin
            rs_ff     <= xs_ff;
            rn_res_ff <= rn_ff;
            rd_res_ff <= dv_q_ff;
         end
      end
      if (cmd.out_load) begin
         o_s_ff  <= rs_ff;
         o_n_ff  <= rn_res_ff;
         o_d_ff  <= rd_res_ff;
         o_st_ff <= st_ff;
         o_eq_ff <= req_ff;
      end
   end

   assign sts.op       = op_ff;
   assign sts.err      = err_ff;
   assign sts.gcd_done = (gx_ff == '0) || (gy_ff == '0);
   assign sts.div_last = (dv_cnt_ff == KW'(W - 1));
   assign sts.pass     = pass_ff;

   assign rsp_res_sign        = o_s_ff;
   assign rsp_res_numerator   = PB'(o_n_ff);
   assign rsp_res_denominator = PB'(o_d_ff);
   assign rsp_status          = o_st_ff;
   assign rsp_is_equal        = o_eq_ff;

endmodule

// ===== rtl/rau_controller.sv =====
// sequencer that steps the datapath through one item and owns both handshakes
module rau_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  rau_pkg::sts_type sts,
   output rau_pkg::cmd_type cmd
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_DISP   = 13'b0000000000010,
      S_MUL0   = 13'b0000000000100,
      S_MUL1   = 13'b0000000001000,
      S_MUL2   = 13'b0000000010000,
      S_COMB   = 13'b0000000100000,
      S_GCD    = 13'b0000001000000,
      S_DIVN   = 13'b0000010000000,
      S_D2D    = 13'b0000100000000,
      S_DIVD   = 13'b0001000000000,
      S_REND   = 13'b0010000000000,
      S_REINIT = 13'b0100000000000,
      S_WRITE  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.err) begin
               state_in = S_WRITE;
            end else begin
               case (sts.op)
                  rau_pkg::OP_ADD, rau_pkg::OP_SUB,
                  rau_pkg::OP_MUL, rau_pkg::OP_DIV: state_in = S_MUL0;
                  rau_pkg::OP_RED, rau_pkg::OP_EQU: begin
                     cmd.gcd_init = 1'b1;
                     state_in     = S_GCD;
                  end
                  default: state_in = S_WRITE;
               endcase
            end
         end
         S_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = rau_pkg::MUL_IDX_0;
            state_in    = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = rau_pkg::MUL_IDX_1;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = rau_pkg::MUL_IDX_2;
            state_in    = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = S_WRITE;
         end
         S_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_D2D;
            end
         end
         S_D2D: begin
            cmd.save_n   = 1'b1;
            cmd.div_init = 1'b1;
            state_in     = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_REND;
            end
         end
         S_REND: begin
            cmd.red_end = 1'b1;
            if ((sts.op == rau_pkg::OP_EQU) && !sts.pass) begin
               state_in = S_REINIT;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_REINIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = S_GCD;
         end
         S_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// top level of the rational arithmetic unit: controller plus datapath
// Sign-magnitude rational unit: add, subtract, multiply, divide, reduce and
// equality on operands of VALUE_BITS-bit numerator and denominator, one result
// beat per request beat. One item is in flight at a time; the next request is
// taken once the result sits in the output register, even while that beat is
// still stalled. Add, subtract, multiply and divide make three passes through
// the single VALUE_BITS x VALUE_BITS multiplier, then a combine step. Reduce
// runs a binary gcd (one shift or subtract per cycle) and then two passes
// through the restoring divider; equal does that for both operands.
// Errors found at capture (zero denominator, zero divisor) skip straight to
// the output. No clearing pass or memory is involved.
module rational_arithmetic_unit #(
   parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rau_pkg::OP_BITS-1:0]      req_opcode,
   input  logic                             req_a_sign,
   input  logic [rau_pkg::PORT_BITS-1:0]    req_a_numerator,
   input  logic [rau_pkg::PORT_BITS-1:0]    req_a_denominator,
   input  logic                             req_b_sign,
   input  logic [rau_pkg::PORT_BITS-1:0]    req_b_numerator,
   input  logic [rau_pkg::PORT_BITS-1:0]    req_b_denominator,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_res_sign,
   output logic [rau_pkg::PORT_BITS-1:0]    rsp_res_numerator,
   output logic [rau_pkg::PORT_BITS-1:0]    rsp_res_denominator,
   output logic [rau_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic                             rsp_is_equal
);

   // command and status between sequencer and datapath
   rau_pkg::cmd_type cmd;
   rau_pkg::sts_type sts;

   // sequencer: handshakes and step order
   rau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: operands, multiplier, gcd, divider, result beat
   rau_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock               (clock),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_opcode          (req_opcode),
      .req_a_sign          (req_a_sign),
      .req_a_numerator     (req_a_numerator),
      .req_a_denominator   (req_a_denominator),
      .req_b_sign          (req_b_sign),
      .req_b_numerator     (req_b_numerator),
      .req_b_denominator   (req_b_denominator),
      .rsp_res_sign        (rsp_res_sign),
      .rsp_res_numerator   (rsp_res_numerator),
      .rsp_res_denominator (rsp_res_denominator),
      .rsp_status          (rsp_status),
      .rsp_is_equal        (rsp_is_equal)
   );

endmodule

// ===== rtl/rau_checker.sv =====
// port-level checks of the rational arithmetic unit and their bind
`include "rational_arithmetic_unit_macros.svh"

module rau_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [rau_pkg::OP_BITS-1:0]      req_opcode,
   input logic                             req_a_sign,
   input logic [rau_pkg::PORT_BITS-1:0]    req_a_numerator,
   input logic [rau_pkg::PORT_BITS-1:0]    req_a_denominator,
   input logic                             req_b_sign,
   input logic [rau_pkg::PORT_BITS-1:0]    req_b_numerator,
   input logic [rau_pkg::PORT_BITS-1:0]    req_b_denominator,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_res_sign,
   input logic [rau_pkg::PORT_BITS-1:0]    rsp_res_numerator,
   input logic [rau_pkg::PORT_BITS-1:0]    rsp_res_denominator,
   input logic [rau_pkg::STATUS_BITS-1:0]  rsp_status,
   input logic                             rsp_is_equal
);

   // a stalled result beat stays offered
   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // one item at a time: busy right after a request beat
   `RAU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // error beats carry +0/1 and no match
   `RAU_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && (rsp_status != rau_pkg::ST_OK), !rsp_res_sign && (rsp_res_numerator == '0) && (rsp_res_denominator == 32'd1) && !rsp_is_equal)

   // zero results are normalized
   `RAU_ASSERT_NOW(a_zero_norm, clock, reset, rsp_valid && (rsp_res_numerator == '0), !rsp_res_sign && (rsp_res_denominator == 32'd1))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench for the rational arithmetic unit
`timescale 1ns / 100ps

module tb_top;

   localparam int          CYCLE_LIMIT = 5000000;
   localparam int          DRAIN_CYCLES = 600;
   localparam logic [63:0] FIELD_MAX = 64'hFFFF_FFFF;

   // one request beat
   typedef struct {
      logic [rau_pkg::OP_BITS-1:0] opcode;
      logic               a_sign;
      logic [31:0]        a_num;
      logic [31:0]        a_den;
      logic               b_sign;
      logic [31:0]        b_num;
      logic [31:0]        b_den;
   } rat_req_type;

   // one response beat
   typedef struct {
      logic                   sign;
      logic [31:0]            num;
      logic [31:0]            den;
      logic [rau_pkg::STATUS_BITS-1:0] status;
      logic                   is_equal;
   } rat_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [rau_pkg::OP_BITS-1:0]     req_opcode = rau_pkg::OP_ADD;
   logic                   req_a_sign = 1'b0;
   logic [rau_pkg::PORT_BITS-1:0]   req_a_numerator = '0;
   logic [rau_pkg::PORT_BITS-1:0]   req_a_denominator = 32'd1;
   logic                   req_b_sign = 1'b0;
   logic [rau_pkg::PORT_BITS-1:0]   req_b_numerator = '0;
   logic [rau_pkg::PORT_BITS-1:0]   req_b_denominator = 32'd1;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_res_sign;
   logic [rau_pkg::PORT_BITS-1:0]   rsp_res_numerator;
   logic [rau_pkg::PORT_BITS-1:0]   rsp_res_denominator;
   logic [rau_pkg::STATUS_BITS-1:0] rsp_status;
   logic                   rsp_is_equal;

   rational_arithmetic_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_a_sign          (req_a_sign),
      .req_a_numerator     (req_a_numerator),
      .req_a_denominator   (req_a_denominator),
      .req_b_sign          (req_b_sign),
      .req_b_numerator     (req_b_numerator),
      .req_b_denominator   (req_b_denominator),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_res_sign        (rsp_res_sign),
      .rsp_res_numerator   (rsp_res_numerator),
      .rsp_res_denominator (rsp_res_denominator),
      .rsp_status          (rsp_status),
      .rsp_is_equal        (rsp_is_equal)
   );

   always #5 clock = ~clock;

   rat_req_type pending_reqs[$];    // beats still to be offered
   rat_req_type offered_req;        // beat currently on the request port
   rat_rsp_type expected_rsps[$];   // predicted responses, oldest first
   int       error_count = 0;
   int       accepted_count = 0;
   int       cycle_count = 0;
   bit       req_taken = 1'b0;   // request beat accepted at the last rising edge
   int       sender_idle_pct = 34;
   int       receiver_idle_pct = 56;
   int       hold_left = 0;
   bit       hold_used = 1'b0;

   // ---------------------------------------------------------------------------
   // arithmetic predictor
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
      while (x != 0 && y != 0) begin
         if (x > y) x = x % y;
         else       y = y % x;
      end
      return x + y;
   endfunction

   // signed sum of two zero-normalized operands, returns status
   function automatic logic [rau_pkg::STATUS_BITS-1:0] rat_add(
      input logic as, input logic [63:0] an, input logic [63:0] ad,
      input logic bs, input logic [63:0] bn, input logic [63:0] bd,
      output logic rs, output logic [63:0] rn, output logic [63:0] rd);
      logic [63:0] p1, p2, den;
      rs = 1'b0; rn = 0; rd = 1;
      if (as == bs) begin
         if (ad == bd) begin
            p1 = an + bn;
            if (p1 > FIELD_MAX) return rau_pkg::ST_OVF;
            den = ad;
         end else begin
            p1 = an * bd;
            if (p1 > FIELD_MAX) return rau_pkg::ST_OVF;
            p2 = bn * ad;
            if (p2 > FIELD_MAX) return rau_pkg::ST_OVF;
            p1 = p1 + p2;
            if (p1 > FIELD_MAX) return rau_pkg::ST_OVF;
            den = ad * bd;
            if (den > FIELD_MAX) return rau_pkg::ST_OVF;
         end
         rs = as;
      end else begin
         if (ad == bd) begin
            // equal denominators: plain difference of magnitudes
            p1 = an; p2 = bn; den = ad;
         end else begin
            p1 = an * bd;
            if (p1 > FIELD_MAX) return rau_pkg::ST_OVF;
            p2 = bn * ad;
            if (p2 > FIELD_MAX) return rau_pkg::ST_OVF;
            den = ad * bd;
            if (den > FIELD_MAX) return rau_pkg::ST_OVF;
         end
         if (p1 >= p2) begin
            rs = as; p1 = p1 - p2;
         end else begin
            rs = bs; p1 = p2 - p1;
         end
      end
      rn = p1;
      rd = den;
      if (rn == 0) begin rs = 1'b0; rd = 1; end
      return rau_pkg::ST_OK;
   endfunction

   function automatic logic [rau_pkg::STATUS_BITS-1:0] rat_mul(
      input logic as, input logic [63:0] an, input logic [63:0] ad,
      input logic bs, input logic [63:0] bn, input logic [63:0] bd,
      output logic rs, output logic [63:0] rn, output logic [63:0] rd);
      rs = 1'b0; rn = 0; rd = 1;
      if (an * bn > FIELD_MAX) return rau_pkg::ST_OVF;
      if (ad * bd > FIELD_MAX) return rau_pkg::ST_OVF;
      rs = as ^ bs;
      rn = an * bn;
      rd = ad * bd;
      if (rn == 0) begin rs = 1'b0; rd = 1; end
      return rau_pkg::ST_OK;
   endfunction

   // lowest terms; zero comes out as +0/1
   function automatic void rat_reduce(inout logic s, inout logic [63:0] n,
                                      inout logic [63:0] d);
      logic [63:0] g;
      g = gcd_u64(n, d);
      if (g != 0) begin n = n / g; d = d / g; end
      if (n == 0) begin s = 1'b0; d = 1; end
   endfunction

   function automatic rat_rsp_type predict_rational(rat_req_type q);
      logic        as, bs, rs;
      logic [63:0] an, ad, bn, bd, rn, rd;
      logic [rau_pkg::STATUS_BITS-1:0] st;
      logic        eq;
      rat_rsp_type r;
      as = q.a_sign; an = 64'(q.a_num); ad = 64'(q.a_den);
      bs = q.b_sign; bn = 64'(q.b_num); bd = 64'(q.b_den);
      // a zero numerator means +0/1 whatever the sign and denominator
      if (an == 0) begin as = 1'b0; ad = 1; end
      if (bn == 0) begin bs = 1'b0; bd = 1; end
      rs = 1'b0; rn = 0; rd = 1; st = rau_pkg::ST_OK; eq = 1'b0;
      if (q.opcode <= rau_pkg::OP_EQU &&
          (ad == 0 || (q.opcode != rau_pkg::OP_RED && bd == 0))) begin
         st = rau_pkg::ST_DIV0;
      end else begin
         case (q.opcode)
            rau_pkg::OP_ADD: st = rat_add(as, an, ad, bs, bn, bd, rs, rn, rd);
            rau_pkg::OP_SUB: begin
               if (bn != 0) bs = ~bs;
               st = rat_add(as, an, ad, bs, bn, bd, rs, rn, rd);
            end
            rau_pkg::OP_MUL: st = rat_mul(as, an, ad, bs, bn, bd, rs, rn, rd);
            rau_pkg::OP_DIV: begin
               // multiply by the reciprocal of the divisor
               if (bn == 0) st = rau_pkg::ST_DIV0;
               else st = rat_mul(as, an, ad, bs, bd, bn, rs, rn, rd);
            end
            rau_pkg::OP_RED: begin
               rs = as; rn = an; rd = ad;
               rat_reduce(rs, rn, rd);
            end
            rau_pkg::OP_EQU: begin
               rat_reduce(as, an, ad);
               rat_reduce(bs, bn, bd);
               eq = (as == bs && an == bn && ad == bd);
            end
            default: ;
         endcase
      end
      if (st != rau_pkg::ST_OK) begin
         rs = 1'b0; rn = 0; rd = 1; eq = 1'b0;
      end
      r.sign = rs;
      r.num = rn[31:0];
      r.den = rd[31:0];
      r.status = st;
      r.is_equal = eq;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // magnitude spread over extremes, small, byte, half-word and full ranges
   function automatic logic [31:0] pick_value(bit nonzero);
      logic [31:0] v;
      case ($urandom_range(9))
         0:       v = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'd1;
         1, 2, 3: v = $urandom_range(16);
         4, 5:    v = $urandom_range(255);
         6, 7:    v = $urandom_range(65535);
         default: v = $urandom;
      endcase
      if (nonzero && v == 0) v = 32'd1;
      return v;
   endfunction

   function automatic rat_req_type random_request();
      rat_req_type q;
      logic [31:0] k;
      q.opcode = rau_pkg::OP_BITS'($urandom_range(rau_pkg::OP_EQU));
      q.a_sign = 1'($urandom_range(1));
      q.b_sign = 1'($urandom_range(1));
      q.a_num  = ($urandom_range(19) == 0) ? 32'd0 : pick_value(1'b0);
      q.a_den  = pick_value(1'b1);
      q.b_num  = ($urandom_range(19) == 0) ? 32'd0 : pick_value(1'b0);
      q.b_den  = pick_value(1'b1);
      // shared denominators take their own path in add and subtract
      if ($urandom_range(3) == 0) q.b_den = q.a_den;
      // scaled copy of a so that equal sees matching values
      if (q.opcode == rau_pkg::OP_EQU && $urandom_range(1) == 1) begin
         q.a_num = $urandom_range(4000);
         q.a_den = $urandom_range(4000, 1);
         k = $urandom_range(9000, 1);
         q.b_num = q.a_num * k;
         q.b_den = q.a_den * k;
         q.b_sign = ($urandom_range(3) == 0) ? ~q.a_sign : q.a_sign;
      end
      return q;
   endfunction

   function automatic rat_req_type make_req(logic [rau_pkg::OP_BITS-1:0] op,
      logic as, logic [31:0] an, logic [31:0] ad,
      logic bs, logic [31:0] bn, logic [31:0] bd);
      rat_req_type q;
      q.opcode = op;
      q.a_sign = as; q.a_num = an; q.a_den = ad;
      q.b_sign = bs; q.b_num = bn; q.b_den = bd;
      return q;
   endfunction

   task automatic report_mismatch(string field, longint unsigned got,
                                  longint unsigned want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, field, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------
   // request driver: changes the port at the falling edge
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         // a beat still waiting for acceptance must stay put
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered_req       <= pending_reqs[0];
               req_opcode        <= pending_reqs[0].opcode;
               req_a_sign        <= pending_reqs[0].a_sign;
               req_a_numerator   <= pending_reqs[0].a_num;
               req_a_denominator <= pending_reqs[0].a_den;
               req_b_sign        <= pending_reqs[0].b_sign;
               req_b_numerator   <= pending_reqs[0].b_num;
               req_b_denominator <= pending_reqs[0].b_den;
               req_valid         <= 1'b1;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response stall: random, plus one long hold-off to back up the unit
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_used && accepted_count >= 150) begin
            hold_used = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: samples both channels at the rising edge
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rat_rsp_type want;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            expected_rsps.push_back(predict_rational(offered_req));
            accepted_count++;
            // idle pattern follows progress through the run
            if (accepted_count == 500) begin
               sender_idle_pct = 56; receiver_idle_pct = 34;
            end else if (accepted_count == 1000) begin
               sender_idle_pct = 0; receiver_idle_pct = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("unexpected response beat at cycle %0d", cycle_count);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_res_sign !== want.sign)
                  report_mismatch("res_sign", rsp_res_sign, want.sign);
               if (rsp_res_numerator !== want.num)
                  report_mismatch("res_numerator", rsp_res_numerator, want.num);
               if (rsp_res_denominator !== want.den)
                  report_mismatch("res_denominator", rsp_res_denominator, want.den);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_is_equal !== want.is_equal)
                  report_mismatch("is_equal", rsp_is_equal, want.is_equal);
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin
      // directed corners first
      pending_reqs.push_back(make_req(rau_pkg::OP_ADD, 0, 32'hFFFF_FFFF, 7, 0, 1, 7));
      pending_reqs.push_back(make_req(rau_pkg::OP_ADD, 0, 32'hFFFF_FFFF, 2, 0, 1, 3));
      pending_reqs.push_back(make_req(rau_pkg::OP_ADD, 1, 5, 32'h1_0000, 1, 3, 32'h1_0001));
      pending_reqs.push_back(make_req(rau_pkg::OP_ADD, 0, 3, 4, 1, 3, 4));
      pending_reqs.push_back(make_req(rau_pkg::OP_ADD, 1, 0, 32'hFFFF_FFFF, 1, 2, 5));
      pending_reqs.push_back(make_req(rau_pkg::OP_SUB, 0, 1, 2, 1, 1, 3));
      pending_reqs.push_back(make_req(rau_pkg::OP_SUB, 1, 9, 11, 1, 9, 11));
      pending_reqs.push_back(make_req(rau_pkg::OP_SUB, 0, 2, 9, 0, 7, 9));
      pending_reqs.push_back(make_req(rau_pkg::OP_SUB, 0, 32'hFFFF_FFFF, 1, 1, 1, 2));
      pending_reqs.push_back(make_req(rau_pkg::OP_SUB, 1, 4, 5, 1, 0, 1));
      pending_reqs.push_back(make_req(rau_pkg::OP_MUL, 1, 32'h1_0000, 3, 0, 32'h1_0000, 5));
      pending_reqs.push_back(make_req(rau_pkg::OP_MUL, 1, 3, 4, 1, 5, 6));
      pending_reqs.push_back(make_req(rau_pkg::OP_MUL, 0, 2, 32'h1_0000, 1, 3, 32'h1_0000));
      pending_reqs.push_back(make_req(rau_pkg::OP_MUL, 1, 0, 9, 0, 5, 6));
      pending_reqs.push_back(make_req(rau_pkg::OP_DIV, 0, 3, 4, 1, 0, 7));
      pending_reqs.push_back(make_req(rau_pkg::OP_DIV, 1, 3, 4, 1, 5, 6));
      pending_reqs.push_back(make_req(rau_pkg::OP_DIV, 0, 32'hFFFF_FFFF, 1, 0, 1,
                                      32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(rau_pkg::OP_RED, 1, 12, 18, 0, 0, 1));
      pending_reqs.push_back(make_req(rau_pkg::OP_RED, 1, 0, 32'hFFFF_FFFF, 1, 5, 5));
      pending_reqs.push_back(make_req(rau_pkg::OP_RED, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      0, 1, 1));
      pending_reqs.push_back(make_req(rau_pkg::OP_RED, 0, 32'hFFFF_FFFE, 32'h8000_0000,
                                      1, 3, 1));
      pending_reqs.push_back(make_req(rau_pkg::OP_EQU, 0, 1, 2, 0, 2, 4));
      pending_reqs.push_back(make_req(rau_pkg::OP_EQU, 1, 0, 3, 0, 0, 5));
      pending_reqs.push_back(make_req(rau_pkg::OP_EQU, 1, 1, 2, 0, 1, 2));
      pending_reqs.push_back(make_req(rau_pkg::OP_EQU, 0, 32'hFFFF_FFFF, 1, 0,
                                      32'hFFFF_FFFE, 1));
      repeat (1500) pending_reqs.push_back(random_request());

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      // catch any stray beat after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
